// ===== rtl/x86_16_mov_arith_instruction_decoder_core_assert.svh =====
// Assertion macros for the 16-bit mov/arith instruction decoder.
// Included by the RTL modules that carry concurrent assertions; needs nothing else.
`ifndef X86_16_MOV_ARITH_INSTRUCTION_DECODER_CORE_ASSERT_SVH
`define X86_16_MOV_ARITH_INSTRUCTION_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define X86DEC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define X86DEC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/x86dec_pkg.sv =====
// Shared types, codes and opcode decode functions of the x86 mov/arith decoder.
// Used by x86dec_record and the top level; depends on nothing.
package x86dec_pkg;

  typedef enum logic [3:0] {
    K_NONE,
    K_LOAD_ACC,
    K_STORE_ACC,
    K_MOV_IMM_RM,
    K_ARITH_IMM_RM,
    K_MOV_RM,
    K_MOV_IMM_REG,
    K_ARITH_IMM_ACC,
    K_ARITH_RM
  } kind_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_OP  = 2'd1;
  localparam logic [1:0] ST_TRUNC   = 2'd2;

  localparam logic [1:0] OP_MOV = 2'd0;
  localparam logic [1:0] OP_ADD = 2'd1;
  localparam logic [1:0] OP_SUB = 2'd2;
  localparam logic [1:0] OP_CMP = 2'd3;

  localparam logic [2:0] FM_REG_RM     = 3'd0;
  localparam logic [2:0] FM_IMM_RM     = 3'd1;
  localparam logic [2:0] FM_IMM_REG    = 3'd2;
  localparam logic [2:0] FM_IMM_ACC    = 3'd3;
  localparam logic [2:0] FM_MEM_TO_ACC = 3'd4;
  localparam logic [2:0] FM_ACC_TO_MEM = 3'd5;

  localparam logic [2:0] ALU_ADD = 3'b000;
  localparam logic [2:0] ALU_SUB = 3'b101;
  localparam logic [2:0] ALU_CMP = 3'b111;

  localparam logic [2:0] RM_DIRECT = 3'b110;
  localparam logic [15:0] SEXT_HIGH = 16'hFF00;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  operation;
    logic [2:0]  form;
    logic        wide;
    logic        to_register;
    logic [2:0]  reg_field;
    logic [1:0]  mod_field;
    logic [2:0]  rm_field;
    logic [15:0] displacement;
    logic [15:0] immediate;
    logic [2:0]  length;
  } rec_t;

  function automatic kind_t kind_of(input logic [7:0] b);
    kind_t k;
    if (b[7:1] == 7'b1010000)                        k = K_LOAD_ACC;
    else if (b[7:1] == 7'b1010001)                   k = K_STORE_ACC;
    else if (b[7:1] == 7'b1100011)                   k = K_MOV_IMM_RM;
    else if (b[7:2] == 6'b100000)                    k = K_ARITH_IMM_RM;
    else if (b[7:2] == 6'b100010)                    k = K_MOV_RM;
    else if (b[7:4] == 4'b1011)                      k = K_MOV_IMM_REG;
    else if (b[7:6] == 2'b00 && b[2:1] == 2'b10)     k = K_ARITH_IMM_ACC;
    else if (b[7:6] == 2'b00 && b[2] == 1'b0)        k = K_ARITH_RM;
    else                                             k = K_NONE;
    return k;
  endfunction

  function automatic logic has_modrm(input kind_t k);
    return (k == K_MOV_IMM_RM) || (k == K_ARITH_IMM_RM) ||
           (k == K_MOV_RM) || (k == K_ARITH_RM);
  endfunction

  function automatic logic [1:0] disp_len(input kind_t k, input logic [7:0] a);
    logic [1:0] n;
    n = 2'd0;
    if (has_modrm(k)) begin
      case (a[7:6])
        2'd0:    n = (a[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
        2'd1:    n = 2'd1;
        2'd2:    n = 2'd2;
        default: n = 2'd0;
      endcase
    end
    return n;
  endfunction

  function automatic logic [1:0] imm_len(input kind_t k, input logic [7:0] b);
    logic [1:0] n;
    case (k)
      K_LOAD_ACC, K_STORE_ACC:       n = 2'd2;
      K_MOV_IMM_RM, K_ARITH_IMM_ACC: n = b[0] ? 2'd2 : 2'd1;
      K_ARITH_IMM_RM:                n = (!b[1] && b[0]) ? 2'd2 : 2'd1;
      K_MOV_IMM_REG:                 n = b[3] ? 2'd2 : 2'd1;
      default:                       n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] arith_op(input logic [2:0] op);
    logic [1:0] r;
    case (op)
      ALU_ADD: r = OP_ADD;
      ALU_SUB: r = OP_SUB;
      ALU_CMP: r = OP_CMP;
      default: r = OP_MOV;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/x86dec_record.sv =====
// Builds the result record of a completed instruction from the gathered bytes.
// Combinational; depends on x86dec_pkg.
module x86dec_record (
  input  x86dec_pkg::kind_t kind,
  input  logic [7:0]        first_byte,
  input  logic [7:0]        addr_byte,
  input  logic [15:0]       disp_bytes,
  input  logic [15:0]       imm_bytes,
  input  logic [2:0]        length,
  output x86dec_pkg::rec_t  rec
);
  import x86dec_pkg::*;

  logic        mr;
  logic [15:0] disp_x;
  logic [15:0] imm_x;

  assign mr = has_modrm(kind);

  always_comb begin
    disp_x = disp_bytes;
    if (disp_len(kind, addr_byte) == 2'd1 && disp_bytes[7]) begin
      disp_x = disp_bytes | SEXT_HIGH;
    end
    // The s bit only widens a byte immediate when the operand is a word.
    imm_x = imm_bytes;
    if (kind == K_ARITH_IMM_RM && first_byte[1] && first_byte[0] && imm_bytes[7]) begin
      imm_x = imm_bytes | SEXT_HIGH;
    end
  end

  always_comb begin
    rec              = '0;
    rec.wide         = first_byte[0];
    rec.displacement = disp_x;
    rec.immediate    = imm_x;
    rec.length       = length;
    if (mr) begin
      rec.mod_field = addr_byte[7:6];
      rec.reg_field = addr_byte[5:3];
      rec.rm_field  = addr_byte[2:0];
    end
    case (kind)
      K_LOAD_ACC:   rec.form = FM_MEM_TO_ACC;
      K_STORE_ACC:  rec.form = FM_ACC_TO_MEM;
      K_MOV_IMM_RM: rec.form = FM_IMM_RM;
      K_ARITH_IMM_RM: begin
        rec.form      = FM_IMM_RM;
        rec.operation = arith_op(addr_byte[5:3]);
      end
      K_MOV_RM: begin
        rec.form        = FM_REG_RM;
        rec.to_register = first_byte[1];
      end
      K_MOV_IMM_REG: begin
        rec.form      = FM_IMM_REG;
        rec.wide      = first_byte[3];
        rec.reg_field = first_byte[2:0];
      end
      K_ARITH_IMM_ACC: begin
        rec.form      = FM_IMM_ACC;
        rec.operation = arith_op(first_byte[5:3]);
      end
      default: begin
        rec.form        = FM_REG_RM;
        rec.to_register = first_byte[1];
        rec.operation   = arith_op(first_byte[5:3]);
      end
    endcase
    if ((kind == K_ARITH_IMM_RM || kind == K_ARITH_IMM_ACC || kind == K_ARITH_RM) &&
        rec.operation == OP_MOV) begin
      rec.status = ST_BAD_OP;
    end
  end

endmodule

// ===== rtl/x86_16_mov_arith_instruction_decoder_core.sv =====
// Top level of the byte-serial 16-bit x86 mov/add/sub/cmp decoder.
// Depends on x86dec_pkg, x86dec_record and the assertion macro header.
//
// Usage
// The input channel (in_valid/in_ready) carries one code byte per item,
// with in_stream_end marking the final byte of a code stream. The result
// channel (out_valid/out_ready) carries one decoded instruction record per
// item. A record is produced on the byte that completes an instruction, or
// with status "stream ended" and the byte count so far when the stream ends
// in the middle of one. A first byte that begins none of the known forms is
// dropped with no record.
// The record of a completing byte is registered and shown at out_valid in
// the cycle after that byte is accepted. Throughput is one byte per cycle
// unless the receiver stalls; each byte only updates the small decode state,
// and the single output register is refilled in the same cycle it is emptied.
// When the receiver stalls with a record waiting, in_ready drops so that no
// byte that could produce a second record is accepted.
// Reset (synchronous, active low on rst_n) returns the decoder to waiting for
// the first byte of an instruction and empties the output register.
module x86_16_mov_arith_instruction_decoder_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_code_byte,
  input  logic               in_stream_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [1:0]         out_operation,
  output logic [2:0]         out_form,
  output logic               out_wide,
  output logic               out_to_register,
  output logic [2:0]         out_reg_field,
  output logic [1:0]         out_mod_field,
  output logic [2:0]         out_rm_field,
  output logic signed [15:0] out_displacement,
  output logic [15:0]        out_immediate,
  output logic [2:0]         out_length
);
  import x86dec_pkg::*;

  // Which byte of the instruction is expected next.
  typedef enum logic [1:0] {
    PH_FIRST,
    PH_ADDR,
    PH_DISP,
    PH_IMM
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [15:0] disp_r, disp_nxt;
  logic [15:0] imm_r, imm_nxt;
  logic [2:0]  bytes_r, bytes_nxt;
  logic        out_valid_r;
  rec_t        out_rec_r, rec_nxt;

  logic        accept;
  kind_t       kind_c;
  logic        mr_c;
  logic [1:0]  dl_c;
  logic [1:0]  il_c;
  logic [2:0]  total_c;
  logic [2:0]  head_c;
  logic [2:0]  pos_c;
  logic [2:0]  ipos_c;
  logic        skip_c;
  logic        complete_c;
  logic        abort_c;
  logic        emit_c;
  rec_t        rec_done;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Fold the incoming byte into the decode state as it will stand afterwards.
  always_comb begin
    first_nxt = first_r;
    addr_nxt  = addr_r;
    disp_nxt  = disp_r;
    imm_nxt   = imm_r;
    if (phase_r == PH_FIRST) begin
      first_nxt = in_code_byte;
      addr_nxt  = '0;
      disp_nxt  = '0;
      imm_nxt   = '0;
    end
    kind_c = kind_of(first_nxt);
    mr_c   = has_modrm(kind_c);
    if (phase_r == PH_ADDR) begin
      addr_nxt = in_code_byte;
    end
    dl_c   = disp_len(kind_c, addr_nxt);
    il_c   = imm_len(kind_c, first_nxt);
    // Byte position after the opcode and addressing byte.
    pos_c  = bytes_r - 3'd1 - {2'b00, mr_c};
    ipos_c = pos_c - {1'b0, dl_c};
    if (phase_r == PH_DISP || phase_r == PH_IMM) begin
      if (pos_c < {1'b0, dl_c}) begin
        disp_nxt = disp_r | (pos_c[0] ? {in_code_byte, 8'h00} : {8'h00, in_code_byte});
      end else begin
        imm_nxt = imm_r | (ipos_c[0] ? {in_code_byte, 8'h00} : {8'h00, in_code_byte});
      end
    end
    bytes_nxt = bytes_r + 3'd1;
    head_c    = 3'd1 + {2'b00, mr_c} + {1'b0, dl_c};
    total_c   = head_c + {1'b0, il_c};

    skip_c     = (phase_r == PH_FIRST) && (kind_c == K_NONE);
    complete_c = 1'b0;
    if (mr_c && bytes_nxt == 3'd1) begin
      phase_nxt = PH_ADDR;
    end else if (bytes_nxt >= total_c) begin
      phase_nxt  = PH_FIRST;
      complete_c = 1'b1;
    end else if (bytes_nxt < head_c) begin
      phase_nxt = PH_DISP;
    end else begin
      phase_nxt = PH_IMM;
    end
    abort_c = !complete_c && in_stream_end;
    emit_c  = accept && !skip_c && (complete_c || abort_c);
  end

  x86dec_record u_record (
    .kind       (kind_c),
    .first_byte (first_nxt),
    .addr_byte  (addr_nxt),
    .disp_bytes (disp_nxt),
    .imm_bytes  (imm_nxt),
    .length     (bytes_nxt),
    .rec        (rec_done)
  );

  // A truncated instruction reports only its status and the bytes taken.
  always_comb begin
    rec_nxt = rec_done;
    if (!complete_c) begin
      rec_nxt        = '0;
      rec_nxt.status = ST_TRUNC;
      rec_nxt.length = bytes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIRST;
      bytes_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept && !skip_c) begin
        if (complete_c || abort_c) begin
          phase_r <= PH_FIRST;
          bytes_r <= '0;
        end else begin
          phase_r <= phase_nxt;
          bytes_r <= bytes_nxt;
          first_r <= first_nxt;
          addr_r  <= addr_nxt;
          disp_r  <= disp_nxt;
          imm_r   <= imm_nxt;
        end
      end
      if (emit_c) begin
        out_valid_r <= 1'b1;
        out_rec_r   <= rec_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_rec_r.status;
  assign out_operation    = out_rec_r.operation;
  assign out_form         = out_rec_r.form;
  assign out_wide         = out_rec_r.wide;
  assign out_to_register  = out_rec_r.to_register;
  assign out_reg_field    = out_rec_r.reg_field;
  assign out_mod_field    = out_rec_r.mod_field;
  assign out_rm_field     = out_rec_r.rm_field;
  assign out_displacement = $signed(out_rec_r.displacement);
  assign out_immediate    = out_rec_r.immediate;
  assign out_length       = out_rec_r.length;

`include "x86_16_mov_arith_instruction_decoder_core_assert.svh"

  // Between instructions no byte has been counted.
  `X86DEC_ASSERT_IMPL(a_idle_count, clk, rst_n, phase_r == PH_FIRST, bytes_r == 3'd0, "byte count not clear between instructions")
  // Mid-instruction the count stays inside the longest form.
  `X86DEC_ASSERT_IMPL(a_mid_count, clk, rst_n, phase_r != PH_FIRST, bytes_r != 3'd0 && bytes_r < 3'd6, "byte count out of range mid-instruction")
  // A record that is produced is presented in the next cycle.
  `X86DEC_ASSERT_NEXT(a_emit_shows, clk, rst_n, emit_c, out_valid_r, "produced record not presented")
  // Every presented record carries a plausible length.
  `X86DEC_ASSERT_IMPL(a_out_length, clk, rst_n, out_valid_r, out_rec_r.length != 3'd0 && out_rec_r.length <= 3'd6, "record length out of range")
  // A truncated instruction never reports an operation or form.
  `X86DEC_ASSERT_IMPL(a_trunc_clear, clk, rst_n, out_valid_r && out_rec_r.status == ST_TRUNC, out_rec_r.operation == OP_MOV && out_rec_r.form == FM_REG_RM && out_rec_r.immediate == 16'h0000, "truncated record not cleared")

endmodule
